### rtl/mlft_pkg.sv
// Package for the MAC learning forward table.
// Holds the beat payload types, the controller state type and the command and status structs.
// Depends on nothing; every other file of the block uses it.
package mlft_pkg;

	localparam int MAC_W  = 48;
	localparam int PORT_W = 4;
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] ACTIVE_PORTS_RESET = 5'd16;

	typedef struct packed {
		logic [MAC_W-1:0]  source_mac;
		logic [MAC_W-1:0]  dest_mac;
		logic [PORT_W-1:0] ingress_port;
	} hdr_t;

	typedef struct packed {
		logic [PORT_W-1:0] egress_port;
		logic              table_hit;
		logic              no_port;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the header and restart the scan
		logic issue;   // read the next table entry
		logic commit;  // write back the learned entry and register the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_end;  // every valid entry has been read
		logic busy;    // a read is still on its way to the compare stage
	} status_t;

endpackage

### rtl/mlft_ctrl.sv
// Controller state machine of the MAC learning forward table.
// Sequences header capture, table scan and commit, and owns the input stall and output valid.
// Depends on mlft_pkg.
module mlft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output mlft_pkg::cmd_t    cmd,
	input  mlft_pkg::status_t sts
);

	mlft_pkg::state_t state_q;
	mlft_pkg::state_t state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlft_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.commit | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			mlft_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mlft_pkg::ST_SCAN;
				end
			end
			mlft_pkg::ST_SCAN: begin
				cmd.issue = !sts.at_end;
				if (sts.at_end && !sts.busy) begin
					state_d = mlft_pkg::ST_FINISH;
				end
			end
			mlft_pkg::ST_FINISH: begin
				// The result may only go out once the output register is free.
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = mlft_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlft_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/mlft_dp.sv
// Datapath of the MAC learning forward table: key and port memories, scan, compare and result.
// Holds the active port register and the entry count; driven by commands from mlft_ctrl.
// Depends on mlft_pkg.
module mlft_dp #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mlft_pkg::CFG_W-1:0]      cfg_wdata,
	input  mlft_pkg::hdr_t                  in_data,
	output mlft_pkg::result_t               out_data,
	input  mlft_pkg::cmd_t                  cmd,
	output mlft_pkg::status_t               sts
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(TABLE_ENTRIES);

	logic [mlft_pkg::MAC_W-1:0]  keys_mem [TABLE_ENTRIES];
	logic [mlft_pkg::PORT_W-1:0] ports_mem [TABLE_ENTRIES];

	mlft_pkg::hdr_t              hdr_q;
	logic [mlft_pkg::CFG_W-1:0]  active_q;
	logic [CNT_W-1:0]            used_q;
	logic [CNT_W-1:0]            addr_q;

	logic                        rd_valid_s1;
	logic [mlft_pkg::MAC_W-1:0]  key_s1;
	logic [mlft_pkg::PORT_W-1:0] port_s1;
	logic [IDX_W-1:0]            addr_s1;

	logic                        src_hit_q;
	logic [IDX_W-1:0]            src_slot_q;
	logic                        dst_hit_q;
	logic [mlft_pkg::PORT_W-1:0] dst_port_q;

	mlft_pkg::result_t           res_q;
	mlft_pkg::result_t           res_d;

	logic                        room;
	logic                        same_mac;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_idx;

	assign sts.at_end = (addr_q == used_q);
	assign sts.busy   = rd_valid_s1;

	assign room     = (used_q < DEPTH);
	assign same_mac = (hdr_q.source_mac == hdr_q.dest_mac);
	assign wr_en    = cmd.commit && (src_hit_q || room);
	assign wr_idx   = src_hit_q ? src_slot_q : used_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= mlft_pkg::ACTIVE_PORTS_RESET;
			used_q      <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			src_hit_q   <= 1'b0;
			dst_hit_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			rd_valid_s1 <= cmd.issue;
			if (cmd.load) begin
				addr_q    <= '0;
				src_hit_q <= 1'b0;
				dst_hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					addr_q <= addr_q + CNT_W'(1);
				end
				// Keys are unique, but only the first match is kept in any case.
				if (rd_valid_s1 && !src_hit_q && key_s1 == hdr_q.source_mac) begin
					src_hit_q <= 1'b1;
				end
				if (rd_valid_s1 && !dst_hit_q && key_s1 == hdr_q.dest_mac) begin
					dst_hit_q <= 1'b1;
				end
			end
			if (cmd.commit && !src_hit_q && room) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		key_s1  <= keys_mem[addr_q[IDX_W-1:0]];
		port_s1 <= ports_mem[addr_q[IDX_W-1:0]];
		addr_s1 <= addr_q[IDX_W-1:0];
		if (wr_en) begin
			if (!src_hit_q) begin
				keys_mem[wr_idx] <= hdr_q.source_mac;
			end
			ports_mem[wr_idx] <= hdr_q.ingress_port;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hdr_q <= in_data;
		end
		if (rd_valid_s1 && !src_hit_q && key_s1 == hdr_q.source_mac) begin
			src_slot_q <= addr_s1;
		end
		if (rd_valid_s1 && !dst_hit_q && key_s1 == hdr_q.dest_mac) begin
			dst_port_q <= port_s1;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	// The header is learned before the lookup, so a frame sent to its own source hits
	// with its ingress port whenever the source is in the table after learning.
	always_comb begin
		res_d = '0;
		if (dst_hit_q || (same_mac && room)) begin
			res_d.table_hit   = 1'b1;
			res_d.egress_port = same_mac ? hdr_q.ingress_port : dst_port_q;
		end else if (hdr_q.ingress_port != '0 && active_q != '0) begin
			res_d.egress_port = '0;
		end else if (hdr_q.ingress_port == '0 && active_q > mlft_pkg::CFG_W'(1)) begin
			res_d.egress_port = mlft_pkg::PORT_W'(1);
		end else begin
			res_d.no_port = 1'b1;
		end
	end

	assign out_data = res_q;

endmodule

### rtl/mac_learning_forward_table.sv
// Top level of the MAC learning forward table.
// Joins the controller mlft_ctrl and the datapath mlft_dp; depends on mlft_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one frame header per beat: source MAC,
// destination MAC and ingress port. The block learns the source, then looks up the
// destination, and returns one beat on the output channel (out_valid, out_stall, out_data)
// with the egress port, a hit flag and a no-port flag.
// Headers are handled one at a time. The table is searched by reading one entry per cycle
// from the key and port memories, so the time per header grows with the entries in use;
// the result is registered at the same clock edge at which the block returns to idle and
// is ready for the next header.
// A finished result sits in the output register while the next header is taken in. If the
// receiver still stalls when the next result is ready, the block waits and stalls its input.
// The user writes active_ports through cfg_we and cfg_wdata only while the block is idle;
// the block does not enforce it. Reset empties the table (no clearing pass is needed), sets
// active_ports to 16 and drops out_valid; the block then waits idle for the first header.
module mac_learning_forward_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mlft_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mlft_pkg::hdr_t              in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mlft_pkg::result_t           out_data
);

	mlft_pkg::cmd_t    cmd;
	mlft_pkg::status_t sts;

	mlft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mlft_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### rtl/mlft_checker.sv
// Port-level checker for the MAC learning forward table, with its bind to the top level.
// Watches only the top-level ports; depends on mlft_pkg.
module mlft_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input mlft_pkg::result_t           out_data
);

	// A stalled result beat stays and holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed or dropped while stalled");

	// One header at a time: the beat after an accepted header is always stalled.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on two consecutive cycles");

	// A hit always names a port.
	a_hit_has_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.table_hit && out_data.no_port))
		else $error("table hit reported together with no port");

	// With no port the egress field reads zero.
	a_no_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_port |-> out_data.egress_port == '0)
		else $error("egress port not zero when no port exists");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/sv/mlft_forward_check.sv
// Forwarding checker for the MAC learning forward table testbench.
// Watches the header, result and register ports, predicts every result beat and compares it.
// Depends on mlft_pkg for the beat payload types and widths.
`timescale 1ns / 1ps

module mlft_forward_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mlft_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  mlft_pkg::hdr_t              in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  mlft_pkg::result_t           out_data,
	output int unsigned                 outstanding,
	output int unsigned                 mismatch_count
);
	import mlft_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int PORT_CAP    = 16;

	logic [MAC_W-1:0]  known_mac  [TABLE_DEPTH];
	logic [PORT_W-1:0] known_port [TABLE_DEPTH];
	int                known_count;
	logic [CFG_W-1:0]  port_setting;
	result_t           results_due [$];
	result_t           due;

	function automatic int find_station(logic [MAC_W-1:0] mac);
		for (int i = 0; i < known_count; i++) begin
			if (known_mac[i] == mac)
				return i;
		end
		return -1;
	endfunction

	// Learns the source, then looks up the destination, as the block does for one header.
	function automatic result_t forward_frame(hdr_t hdr);
		int      slot;
		int      ports;
		result_t res;
		slot = find_station(hdr.source_mac);
		if (slot >= 0) begin
			known_port[slot] = hdr.ingress_port;
		end else if (known_count < TABLE_DEPTH) begin
			known_mac[known_count]  = hdr.source_mac;
			known_port[known_count] = hdr.ingress_port;
			known_count++;
		end
		res.egress_port = '0;
		res.table_hit   = 1'b0;
		res.no_port     = 1'b1;
		slot = find_station(hdr.dest_mac);
		if (slot >= 0) begin
			res.egress_port = known_port[slot];
			res.table_hit   = 1'b1;
			res.no_port     = 1'b0;
		end else begin
			ports = (port_setting > PORT_CAP) ? PORT_CAP : int'(port_setting);
			// Walking down leaves the lowest port other than the ingress one.
			for (int p = ports - 1; p >= 0; p--) begin
				if (p != int'(hdr.ingress_port)) begin
					res.egress_port = PORT_W'(p);
					res.no_port     = 1'b0;
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_count    = 0;
			port_setting   = ACTIVE_PORTS_RESET;
			mismatch_count = 0;
			results_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result beat with no header waiting: egress_port %0d table_hit %0b no_port %0b",
						out_data.egress_port, out_data.table_hit, out_data.no_port);
					mismatch_count++;
				end else begin
					due = results_due.pop_front();
					if (out_data.egress_port !== due.egress_port) begin
						$error("egress_port: expected %0d, got %0d", due.egress_port,
							out_data.egress_port);
						mismatch_count++;
					end
					if (out_data.table_hit !== due.table_hit) begin
						$error("table_hit: expected %0b, got %0b", due.table_hit, out_data.table_hit);
						mismatch_count++;
					end
					if (out_data.no_port !== due.no_port) begin
						$error("no_port: expected %0b, got %0b", due.no_port, out_data.no_port);
						mismatch_count++;
					end
				end
			end
			if (cfg_we)
				port_setting = cfg_wdata;
			if (in_valid && !in_stall)
				results_due.push_back(forward_frame(in_data));
		end
		outstanding = results_due.size();
	end

endmodule

### tb/sv/mac_learning_forward_table_test.sv
// Top of the MAC learning forward table testbench: clock, reset, header and stall stimulus.
// Instantiates mac_learning_forward_table and the mlft_forward_check checker; uses mlft_pkg.
`timescale 1ns / 1ps

module mac_learning_forward_table_test;
	import mlft_pkg::*;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 125;
	localparam int POOL_SIZE     = 96;
	localparam int DRAIN_CYCLES  = 80;
	localparam int PHASE_PORTS [RANDOM_PHASES] = '{16, 3, 20, 1, 0, 9};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	hdr_t              in_data;
	logic              out_valid;
	logic              out_stall;
	result_t           out_data;
	int unsigned       outstanding;
	int unsigned       mismatch_count;
	int unsigned       tx_idle_pct;
	int unsigned       rx_idle_pct;
	int unsigned       frames_sent;
	int unsigned       settings_used;
	logic [MAC_W-1:0]  station_pool [POOL_SIZE];

	mac_learning_forward_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	mlft_forward_check forward_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.outstanding    (outstanding),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Drops the header valid and holds off until every result beat has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_ports(input logic [CFG_W-1:0] count);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_frame(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
			input logic [PORT_W-1:0] port);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid             <= 1'b1;
		in_data.source_mac   <= src;
		in_data.dest_mac     <= dst;
		in_data.ingress_port <= port;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		frames_sent++;
	endtask

	initial begin
		logic [MAC_W-1:0] src;
		logic [MAC_W-1:0] dst;
		int unsigned      roll;
		int               window;
		int               picked;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		in_data       = '0;
		tx_idle_pct   = 15;
		rx_idle_pct   = 50;
		frames_sent   = 0;
		settings_used = 0;
		picked        = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			station_pool[i] = {16'($urandom), $urandom};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_ports(5'd16);
		// A frame sent to itself hits the entry it has just learned.
		send_frame(48'h0, 48'h0, 4'd0);
		send_frame(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'd15);
		send_frame(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 4'd0);
		send_frame(48'h5555_5555_5555, 48'h1234_5678_9ABC, 4'd9);
		send_frame(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 4'd3);
		send_frame(48'h0, 48'h0, 4'd7);
		send_frame(48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 4'd12);
		send_frame(48'h8000_0000_0000, 48'h5555_5555_5555, 4'd1);
		// With one port, an ingress on port 0 has nowhere to flood.
		set_ports(5'd1);
		send_frame(48'h1234_5678_9ABC, 48'h0F0F_0F0F_0F0F, 4'd0);
		send_frame(48'h1234_5678_9ABC, 48'hF0F0_F0F0_F0F0, 4'd3);
		send_frame(48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 4'd0);
		set_ports(5'd0);
		send_frame(48'h0F0F_0F0F_0F0F, 48'h7FFF_FFFF_FFFF, 4'd0);
		send_frame(48'h0F0F_0F0F_0F0F, 48'hFFFF_FFFF_FFFE, 4'd15);
		send_frame(48'hF0F0_F0F0_F0F0, 48'h0000_0000_0001, 4'd4);
		// Settings above the port limit saturate.
		set_ports(5'd31);
		send_frame(48'h0000_0000_0002, 48'h7FFF_FFFF_FFFF, 4'd0);
		send_frame(48'h0000_0000_0002, 48'h7FFF_FFFF_FFFF, 4'd15);
		set_ports(5'd17);
		send_frame(48'h0000_0000_0003, 48'h7FFF_FFFF_FFFF, 4'd0);
		set_ports(5'd2);
		send_frame(48'h0000_0000_0004, 48'h7FFF_FFFF_FFFF, 4'd1);
		send_frame(48'h0000_0000_0004, 48'h7FFF_FFFF_FFFF, 4'd0);
		send_frame(48'h0000_0000_0005, 48'h0, 4'd6);

		// The address pool grows past the table size, so the table ends up full.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			tx_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 50 : 0;
			rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 15 : 0;
			set_ports(CFG_W'(PHASE_PORTS[ph]));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				window = (8 + picked / 5 < POOL_SIZE) ? 8 + picked / 5 : POOL_SIZE;
				if ($urandom_range(99) < 85)
					src = station_pool[$urandom_range(window - 1)];
				else
					src = {16'($urandom), $urandom};
				roll = $urandom_range(99);
				if (roll < 70)
					dst = station_pool[$urandom_range(window - 1)];
				else if (roll < 80)
					dst = src;
				else
					dst = {16'($urandom), $urandom};
				send_frame(src, dst, PORT_W'($urandom_range(15)));
				picked++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Forwarded %0d frame headers under %0d port-count settings, filling the table",
			frames_sent, settings_used);
		$display("from empty to full, with sender and receiver stalls in turn and then none.");
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/mlft_pkg.sv
rtl/mlft_ctrl.sv
rtl/mlft_dp.sv
rtl/mac_learning_forward_table.sv
rtl/mlft_checker.sv
tb/sv/mlft_forward_check.sv
tb/sv/mac_learning_forward_table_test.sv
